FILE: hdl/adm_pkg.sv
package adm_pkg;

  // configuration
  localparam int unsigned DZ_W     = 7;
  localparam logic [DZ_W-1:0] DZ_RESET = 7'd5;

  // input fields
  localparam int unsigned IN_W   = 8;
  localparam int unsigned RATE_W = 9;

  // smoothing arithmetic
  localparam int unsigned COEF_W = 13;   // blend weights, signed
  localparam int unsigned PROD_W = 21;   // position times weight
  localparam int unsigned AXIS_W = 22;   // smoothed axis, over 2560
  localparam int unsigned SIDE_W = 23;   // forward +/- turn
  localparam int unsigned MAG_W  = 23;   // side magnitude and divisor

  // normalisation
  localparam int unsigned LANES      = 2;   // left, right
  localparam int unsigned Q_FRAC     = 16;
  localparam int unsigned Q16_ONE    = 1 << Q_FRAC;
  localparam int unsigned QUOT_W     = Q_FRAC + 1;
  localparam int unsigned NUM_W      = MAG_W + QUOT_W;
  localparam int unsigned FULL_SCALE = 256000;

  // curve
  localparam int unsigned SQ_W    = 2 * Q_FRAC + 1;
  localparam int unsigned T_W     = Q_FRAC + 2;
  localparam int unsigned PROD2_W = SQ_W + Q_FRAC;
  localparam int unsigned P_W     = PROD2_W - Q_FRAC;
  localparam int unsigned O_W     = 15;
  localparam int unsigned OSC_W   = P_W + O_W;
  localparam int unsigned OUT_W   = 16;
  localparam int unsigned OUT_FULL = 25600;

  typedef struct packed {
    logic             neg;
    logic [NUM_W-1:0] num;
  } div_in_t;

  typedef struct packed {
    logic              neg;
    logic [MAG_W-1:0]  rem;
    logic [QUOT_W-1:0] lq;    // numerator bits still to use, quotient bits shifting in
  } div_lane_t;

  typedef struct packed {
    logic              neg;
    logic [QUOT_W-1:0] quot;
  } div_out_t;

endpackage

FILE: hdl/adm_divider.sv
// Pipelined restoring divider, one quotient bit per stage, two lanes sharing a divisor.
module adm_divider (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         en_i,
  input  logic                                         valid_i,
  input  logic [adm_pkg::MAG_W-1:0]                    den_i,
  input  adm_pkg::div_in_t [adm_pkg::LANES-1:0]        lane_i,
  output logic                                         valid_o,
  output adm_pkg::div_out_t [adm_pkg::LANES-1:0]       lane_o
);

  localparam int unsigned STAGES = adm_pkg::QUOT_W;

  logic [STAGES-1:0]                          valid_q;
  logic [adm_pkg::MAG_W-1:0]                  den_q  [STAGES];
  adm_pkg::div_lane_t [adm_pkg::LANES-1:0]    lane_q [STAGES];

  for (genvar s = 0; s < STAGES; s++) begin : g_stage
    logic [adm_pkg::MAG_W-1:0]               den_in;
    logic                                    v_in;
    adm_pkg::div_lane_t [adm_pkg::LANES-1:0] ln_in;
    adm_pkg::div_lane_t [adm_pkg::LANES-1:0] ln_d;
    logic [adm_pkg::MAG_W:0]                 trial [adm_pkg::LANES];
    logic [adm_pkg::LANES-1:0]               ge;

    if (s == 0) begin : g_head
      // numerator < den * 2^QUOT_W, so its top bits start below the divisor
      assign den_in = den_i;
      assign v_in   = valid_i;
      for (genvar l = 0; l < adm_pkg::LANES; l++) begin : g_ln
        assign ln_in[l] = {lane_i[l].neg, lane_i[l].num};
      end
    end else begin : g_body
      assign den_in = den_q[s-1];
      assign v_in   = valid_q[s-1];
      assign ln_in  = lane_q[s-1];
    end

    always_comb begin
      for (int l = 0; l < adm_pkg::LANES; l++) begin
        trial[l]     = {ln_in[l].rem, ln_in[l].lq[adm_pkg::QUOT_W-1]};
        ge[l]        = trial[l] >= {1'b0, den_in};
        ln_d[l].neg  = ln_in[l].neg;
        ln_d[l].rem  = ge[l] ? adm_pkg::MAG_W'(trial[l] - {1'b0, den_in})
                             : trial[l][adm_pkg::MAG_W-1:0];
        ln_d[l].lq   = {ln_in[l].lq[adm_pkg::QUOT_W-2:0], ge[l]};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (en_i) begin
        valid_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[s]  <= den_in;
        lane_q[s] <= ln_d;
      end
    end
  end

  assign valid_o = valid_q[STAGES-1];

  for (genvar l = 0; l < adm_pkg::LANES; l++) begin : g_out
    assign lane_o[l].neg  = lane_q[STAGES-1][l].neg;
    assign lane_o[l].quot = lane_q[STAGES-1][l].lq;
  end

  // quotient never above one in Q16
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (lane_o[0].quot <= adm_pkg::QUOT_W'(adm_pkg::Q16_ONE)) &&
                (lane_o[1].quot <= adm_pkg::QUOT_W'(adm_pkg::Q16_ONE)))
    else $error("quotient above one");

  // restoring step keeps the remainder below the divisor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (lane_q[STAGES-1][0].rem < den_q[STAGES-1]) &&
                (lane_q[STAGES-1][1].rem < den_q[STAGES-1]))
    else $error("remainder not below divisor");

  // stalled pipeline keeps its valid bits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_i |=> $stable(valid_q))
    else $error("valid bits moved during stall");

endmodule

FILE: hdl/arcade_drive_mixer.sv
// Arcade drive mixer: joystick snapshot in, shaped left and right power out.
// Throughput: one beat per cycle; 28 register stages, of which the 17-stage
// bit-per-stage divider sets the depth. A stalled output freezes the pipeline.
// Reset (rst_ni low, asynchronous): all valid bits clear, dead zone returns to 5.
module arcade_drive_mixer (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // dead zone register
  input  logic                               cfg_we_i,
  input  logic [adm_pkg::DZ_W-1:0]           cfg_wdata_i,
  // snapshot beat
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic signed [adm_pkg::IN_W-1:0]    turn_now_i,
  input  logic signed [adm_pkg::IN_W-1:0]    turn_last_i,
  input  logic signed [adm_pkg::IN_W-1:0]    forward_now_i,
  input  logic signed [adm_pkg::IN_W-1:0]    forward_last_i,
  input  logic [adm_pkg::RATE_W-1:0]         turn_rating_i,
  input  logic [adm_pkg::RATE_W-1:0]         forward_rating_i,
  // power beat
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [adm_pkg::OUT_W-1:0]   left_power_o,
  output logic signed [adm_pkg::OUT_W-1:0]   right_power_o
);

  localparam int unsigned LN = adm_pkg::LANES;

  // blend weights (all over 2560)
  localparam logic [adm_pkg::COEF_W-1:0] KNowBase  = adm_pkg::COEF_W'(1024);
  localparam logic [adm_pkg::COEF_W-1:0] KLastOut  = adm_pkg::COEF_W'(1536);
  localparam logic [adm_pkg::COEF_W-1:0] KLastIn   = adm_pkg::COEF_W'(768);
  localparam logic [adm_pkg::MAG_W-1:0]  FullScale = adm_pkg::MAG_W'(adm_pkg::FULL_SCALE);
  localparam logic [adm_pkg::T_W-1:0]    TThree    = adm_pkg::T_W'(3 * adm_pkg::Q16_ONE);
  localparam logic [adm_pkg::PROD2_W-1:0] PRound   = adm_pkg::PROD2_W'(adm_pkg::Q16_ONE / 2);
  localparam logic [adm_pkg::OSC_W-1:0]  OFull     = adm_pkg::OSC_W'(adm_pkg::OUT_FULL);
  localparam logic [adm_pkg::OSC_W-1:0]  ORound    = adm_pkg::OSC_W'(1) << (2 * adm_pkg::Q_FRAC - 1);
  localparam logic signed [adm_pkg::OUT_W-1:0] PowerMax = adm_pkg::OUT_W'(adm_pkg::OUT_FULL);

  typedef struct packed {
    logic signed [adm_pkg::COEF_W-1:0] k_now;
    logic signed [adm_pkg::COEF_W-1:0] k_last;
  } coef_t;

  // Outside the dead zone: now*(1024+5r) + last*(1536-5r).
  // Inside: last*(768-2r). Weights wrap as two's complement for large r.
  function automatic coef_t smooth_coef(input logic signed [adm_pkg::IN_W-1:0] now,
                                        input logic [adm_pkg::RATE_W-1:0]      r,
                                        input logic [adm_pkg::DZ_W-1:0]        dz);
    logic signed [adm_pkg::IN_W:0]   now_x;
    logic [adm_pkg::IN_W:0]          now_mag;
    logic [adm_pkg::COEF_W-1:0]      r_x;
    logic [adm_pkg::COEF_W-1:0]      r5;
    logic [adm_pkg::COEF_W-1:0]      r2;
    coef_t                           c;
    now_x   = (adm_pkg::IN_W+1)'(now);
    now_mag = now_x[adm_pkg::IN_W] ? $unsigned(-now_x) : $unsigned(now_x);
    r_x     = adm_pkg::COEF_W'(r);
    r5      = (r_x << 2) + r_x;
    r2      = r_x << 1;
    if (now_mag > (adm_pkg::IN_W+1)'(dz)) begin
      c.k_now  = KNowBase + r5;
      c.k_last = KLastOut - r5;
    end else begin
      c.k_now  = '0;
      c.k_last = KLastIn - r2;
    end
    return c;
  endfunction

  logic en;
  logic [adm_pkg::DZ_W-1:0] dead_zone_q;

  // stage valids
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  logic vc1_q, vc2_q, vc3_q, vc4_q, out_valid_q;

  // axis 0 is turn, axis 1 is forward
  coef_t                                coef       [LN];
  logic signed [adm_pkg::IN_W-1:0]      now_in     [LN];
  logic signed [adm_pkg::IN_W-1:0]      last_in    [LN];
  logic signed [adm_pkg::PROD_W-1:0]    prod_now_q [LN];
  logic signed [adm_pkg::PROD_W-1:0]    prod_last_q[LN];
  logic signed [adm_pkg::AXIS_W-1:0]    axis_q     [LN];

  // lane 0 is left, lane 1 is right
  logic signed [adm_pkg::SIDE_W-1:0]    side_q     [LN];
  logic [adm_pkg::MAG_W-1:0]            mag4_q     [LN];
  logic [LN-1:0]                        neg4_q;
  logic [adm_pkg::MAG_W-1:0]            mag5_q     [LN];
  logic [LN-1:0]                        neg5_q;
  logic [adm_pkg::MAG_W-1:0]            den5_q;
  logic [adm_pkg::MAG_W-1:0]            mx;
  adm_pkg::div_in_t [LN-1:0]            div_in_q;
  logic [adm_pkg::MAG_W-1:0]            den6_q;

  logic                                 div_valid;
  adm_pkg::div_out_t [LN-1:0]           div_out;

  logic [adm_pkg::SQ_W-1:0]             sq_q       [LN];
  logic [adm_pkg::T_W-1:0]              t_q        [LN];
  logic [LN-1:0]                        negc1_q;
  logic [adm_pkg::PROD2_W-1:0]          prod2_q    [LN];
  logic [LN-1:0]                        negc2_q;
  logic [adm_pkg::P_W-1:0]              p_q        [LN];
  logic [LN-1:0]                        negc3_q;
  logic [adm_pkg::O_W-1:0]              o_q        [LN];
  logic [LN-1:0]                        negc4_q;
  logic [adm_pkg::PROD2_W-1:0]          p_sum      [LN];
  logic [adm_pkg::OSC_W-1:0]            o_scaled   [LN];
  logic signed [adm_pkg::OUT_W-1:0]     power      [LN];
  logic signed [adm_pkg::OUT_W-1:0]     left_power_q, right_power_q;

  // whole pipeline moves unless a finished beat is held at the output
  assign en         = ~out_valid_q | out_ready_i;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dead_zone_q <= adm_pkg::DZ_RESET;
    end else if (cfg_we_i) begin
      dead_zone_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      v5_q        <= 1'b0;
      v6_q        <= 1'b0;
      vc1_q       <= 1'b0;
      vc2_q       <= 1'b0;
      vc3_q       <= 1'b0;
      vc4_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q        <= in_valid_i;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      v4_q        <= v3_q;
      v5_q        <= v4_q;
      v6_q        <= v5_q;
      vc1_q       <= div_valid;
      vc2_q       <= vc1_q;
      vc3_q       <= vc2_q;
      vc4_q       <= vc3_q;
      out_valid_q <= vc4_q;
    end
  end

  // ---- stage 1: dead zone test and weight products ----
  assign now_in[0]  = turn_now_i;
  assign now_in[1]  = forward_now_i;
  assign last_in[0] = turn_last_i;
  assign last_in[1] = forward_last_i;
  assign coef[0]    = smooth_coef(turn_now_i,    turn_rating_i,    dead_zone_q);
  assign coef[1]    = smooth_coef(forward_now_i, forward_rating_i, dead_zone_q);

  // ---- stage 5: common divisor, at least full scale ----
  assign mx = (mag4_q[0] > mag4_q[1]) ? mag4_q[0] : mag4_q[1];

  // ---- curve rounding terms ----
  always_comb begin
    for (int l = 0; l < LN; l++) begin
      p_sum[l]    = prod2_q[l] + PRound;
      o_scaled[l] = adm_pkg::OSC_W'(p_q[l]) * OFull + ORound;
      power[l]    = negc4_q[l] ? -adm_pkg::OUT_W'(o_q[l]) : adm_pkg::OUT_W'(o_q[l]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int a = 0; a < LN; a++) begin
        // stage 1
        prod_now_q[a]  <= adm_pkg::PROD_W'(now_in[a])  * adm_pkg::PROD_W'(coef[a].k_now);
        prod_last_q[a] <= adm_pkg::PROD_W'(last_in[a]) * adm_pkg::PROD_W'(coef[a].k_last);
        // stage 2
        axis_q[a]      <= adm_pkg::AXIS_W'(prod_now_q[a]) + adm_pkg::AXIS_W'(prod_last_q[a]);
      end
      // stage 3: mix
      side_q[0] <= adm_pkg::SIDE_W'(axis_q[1]) + adm_pkg::SIDE_W'(axis_q[0]);
      side_q[1] <= adm_pkg::SIDE_W'(axis_q[1]) - adm_pkg::SIDE_W'(axis_q[0]);
      for (int l = 0; l < LN; l++) begin
        // stage 4: magnitude and sign
        mag4_q[l] <= side_q[l][adm_pkg::SIDE_W-1] ? $unsigned(-side_q[l]) : $unsigned(side_q[l]);
        neg4_q[l] <= side_q[l][adm_pkg::SIDE_W-1];
        // stage 5
        mag5_q[l] <= mag4_q[l];
        neg5_q[l] <= neg4_q[l];
        // stage 6: |side| * 2^16 + den/2, rounds the quotient half up
        div_in_q[l].neg <= neg5_q[l];
        div_in_q[l].num <= (adm_pkg::NUM_W'(mag5_q[l]) << adm_pkg::Q_FRAC)
                         + adm_pkg::NUM_W'(den5_q >> 1);
        // curve 1: x*x and 3 - 2x
        sq_q[l]    <= adm_pkg::SQ_W'(div_out[l].quot) * adm_pkg::SQ_W'(div_out[l].quot);
        t_q[l]     <= TThree - (adm_pkg::T_W'(div_out[l].quot) << 1);
        negc1_q[l] <= div_out[l].neg;
        // curve 2
        prod2_q[l] <= adm_pkg::PROD2_W'(sq_q[l]) * adm_pkg::PROD2_W'(t_q[l]);
        negc2_q[l] <= negc1_q[l];
        // curve 3: back to Q32
        p_q[l]     <= p_sum[l][adm_pkg::PROD2_W-1:adm_pkg::Q_FRAC];
        negc3_q[l] <= negc2_q[l];
        // curve 4: scale to Q8 percent
        o_q[l]     <= o_scaled[l][2*adm_pkg::Q_FRAC +: adm_pkg::O_W];
        negc4_q[l] <= negc3_q[l];
      end
      den5_q        <= (mx > FullScale) ? mx : FullScale;
      den6_q        <= den5_q;
      // output register: sign restored
      left_power_q  <= power[0];
      right_power_q <= power[1];
    end
  end

  adm_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v6_q),
    .den_i   (den6_q),
    .lane_i  (div_in_q),
    .valid_o (div_valid),
    .lane_o  (div_out)
  );

  assign out_valid_o   = out_valid_q;
  assign left_power_o  = left_power_q;
  assign right_power_o = right_power_q;

  // divisor covers both sides and full scale
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    v5_q |-> (den5_q >= mag5_q[0]) && (den5_q >= mag5_q[1]) && (den5_q >= FullScale))
    else $error("divisor below a side magnitude");

  // curve output never above full power
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vc4_q |-> (o_q[0] <= adm_pkg::O_W'(adm_pkg::OUT_FULL)) &&
              (o_q[1] <= adm_pkg::O_W'(adm_pkg::OUT_FULL)))
    else $error("curve above full scale");

  // delivered power within +/- full scale
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (left_power_o  <= PowerMax) &&
                    (left_power_o  >= -PowerMax) &&
                    (right_power_o <= PowerMax) &&
                    (right_power_o >= -PowerMax))
    else $error("power out of range");

endmodule
